FILE: rtl/trfr_pkg.sv
// Shared types, widths and constants for the throttle rate fuel ramp block.
package trfr_pkg;

	localparam int TIME_W    = 32;
	localparam int TP_W      = 8;
	localparam int VE_W      = 8;
	localparam int RATE_W    = 16;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CHG_W     = TP_W + 1;
	localparam int PROD_W    = 2 * CHG_W;
	localparam int BINMS_W   = 17;
	localparam int MS_W      = 10;
	localparam int DUR_W     = 20;
	localparam int QUOT_W    = 8;
	localparam int NUM_W     = TIME_W + QUOT_W;
	localparam int CP_W      = 2 * VE_W;

	// duration bin to milliseconds: bin * 392 / 100
	localparam logic [BINMS_W-1:0] BIN_MS_NUM = 17'd392;
	// floor(y / 100) == (y * 167773) >> 24 for y < 199728
	localparam int                 RECIP_MS_W  = 18;
	localparam logic [RECIP_MS_W-1:0] RECIP_MS = 18'd167773;
	localparam int                 RECIP_MS_SH = 24;
	localparam logic [MS_W-1:0]    US_PER_MS  = 10'd1000;

	// floor(x / 100) == (x * 5243) >> 19 for x < 43690
	localparam int                 RECIP_VE_W  = 13;
	localparam logic [RECIP_VE_W-1:0] RECIP_VE = 13'd5243;
	localparam int                 RECIP_VE_SH = 19;
	localparam logic [CP_W-1:0]    VE_SAT_LIMIT = 16'd25600;
	localparam logic [VE_W-1:0]    VE_MAX      = 8'd255;
	localparam logic [VE_W-1:0]    VE_UNITY    = 8'd100;

	localparam logic [CFG_W-1:0]   RATE_SCALE_RST = 8'd30;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_SCALE     = 2'd0,
		CFG_RATE_THRESHOLD = 2'd1,
		CFG_MIN_CHANGE     = 2'd2
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic rate;
		logic scale;
		logic dur;
		logic decide;
		logic eval;
		logic clamp;
		logic mul;
		logic div_start;
		logic apply;
		logic comb1;
		logic comb2;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fire_arm;
		logic armed;
		logic ramp_end;
		logic div_done;
	} sts_t;

endpackage

FILE: rtl/trfr_div.sv
// Restoring divider, one quotient bit per cycle, for quotients known to fit QUOT_W bits.
module trfr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [trfr_pkg::NUM_W-1:0]   num,
	input  logic [trfr_pkg::TIME_W-1:0]  den,
	output logic                         done,
	output logic [trfr_pkg::QUOT_W-1:0]  quot
);
	import trfr_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  rem_q;
	logic [TIME_W-1:0]  den_q;
	logic [QUOT_W-1:0]  low_q;
	logic [QUOT_W-1:0]  quot_q;

	logic [TIME_W:0]    trial;
	logic [TIME_W:0]    diff;
	logic               ge;

	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the upper part of the dividend is below the divisor, so it seeds the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NUM_W-1:QUOT_W];
			low_q  <= num[QUOT_W-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			low_q  <= {low_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: rtl/trfr_dp.sv
// Datapath: configuration, ramp state, rate and VE arithmetic, output register.
module trfr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  trfr_pkg::cmd_t                       cmd,
	output trfr_pkg::sts_t                       sts,
	input  logic                                 cfg_we,
	input  logic [trfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [trfr_pkg::CFG_W-1:0]           cfg_data,
	input  logic [trfr_pkg::TIME_W-1:0]          now_us,
	input  logic [trfr_pkg::TP_W-1:0]            throttle_now,
	input  logic [trfr_pkg::TP_W-1:0]            throttle_prev,
	input  logic [trfr_pkg::VE_W-1:0]            primary_ve,
	input  logic [trfr_pkg::VE_W-1:0]            looked_up_ve,
	input  logic [trfr_pkg::VE_W-1:0]            duration_bin,
	output logic signed [trfr_pkg::RATE_W-1:0]   throttle_rate,
	output logic [trfr_pkg::VE_W-1:0]            secondary_ve,
	output logic [trfr_pkg::VE_W-1:0]            combined_ve,
	output logic                                 ve_written,
	output logic                                 enrich_active
);
	import trfr_pkg::*;

	// configuration
	logic [CFG_W-1:0]         rate_scale_q;
	logic [CFG_W-1:0]         rate_threshold_q;
	logic [CFG_W-1:0]         min_change_q;

	// ramp state
	logic                     armed_q;
	logic signed [RATE_W-1:0] trig_rate_q;
	logic [TIME_W-1:0]        start_q;
	logic [TIME_W-1:0]        end_q;
	logic [VE_W-1:0]          start_ve_q;
	logic [VE_W-1:0]          held_q;

	// captured transaction
	logic [TIME_W-1:0]        now_q;
	logic [TP_W-1:0]          tnow_q;
	logic [TP_W-1:0]          tprev_q;
	logic [VE_W-1:0]          prim_q;
	logic [VE_W-1:0]          look_q;
	logic [VE_W-1:0]          bin_q;

	// working registers
	logic signed [PROD_W-1:0] prod_q;
	logic [BINMS_W-1:0]       binms_q;
	logic signed [RATE_W-1:0] rate_q;
	logic [MS_W-1:0]          ms_q;
	logic [DUR_W-1:0]         dur_q;
	logic [TIME_W-1:0]        total_q;
	logic [TIME_W-1:0]        el_q;
	logic [VE_W-1:0]          mdiff_q;
	logic                     neg_q;
	logic [NUM_W-1:0]         num_q;
	logic [CP_W-1:0]          cp_q;
	logic [VE_W-1:0]          comb_q;
	logic                     written_q;

	// output register
	logic signed [RATE_W-1:0] o_rate_q;
	logic [VE_W-1:0]          o_sec_q;
	logic [VE_W-1:0]          o_comb_q;
	logic                     o_written_q;
	logic                     o_active_q;

	logic signed [CHG_W-1:0]  chg;
	logic signed [CHG_W-1:0]  scale_s;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [PROD_W-1:0] prod_adj;
	logic signed [PROD_W-1:0] rate_full;
	logic [TP_W-1:0]          chg_mag;
	logic [RATE_W-1:0]        rate_mag;
	logic [RATE_W-1:0]        trig_mag;
	logic [BINMS_W+RECIP_MS_W-1:0] ms_prod;
	logic [DUR_W-1:0]         dur_prod;
	logic [TIME_W-1:0]        end_new;
	logic                     fire_arm;
	logic                     restart;
	logic [TIME_W-1:0]        total_w;
	logic [TIME_W-1:0]        el_w;
	logic                     ramp_end;
	logic [NUM_W-1:0]         num_w;
	logic [CP_W+RECIP_VE_W-1:0] ve_prod;
	logic [QUOT_W-1:0]        quot;
	logic                     div_done;

	always_comb begin
		chg       = $signed({1'b0, tnow_q}) - $signed({1'b0, tprev_q});
		scale_s   = $signed({1'b0, rate_scale_q});
		prod_w    = scale_s * chg;
		// truncate toward zero: bias negatives up by one before the shift
		prod_adj  = prod_q + $signed({{(PROD_W-1){1'b0}}, prod_q[PROD_W-1]});
		rate_full = prod_adj >>> 1;
		chg_mag   = chg[CHG_W-1] ? TP_W'(-chg) : chg[TP_W-1:0];
		rate_mag  = rate_q[RATE_W-1] ? RATE_W'(-rate_q) : RATE_W'(rate_q);
		trig_mag  = trig_rate_q[RATE_W-1] ? RATE_W'(-trig_rate_q) : RATE_W'(trig_rate_q);
		ms_prod   = binms_q * RECIP_MS;
		dur_prod  = ms_q * US_PER_MS;
		end_new   = now_q + TIME_W'(dur_q);
		fire_arm  = !armed_q && (rate_mag > RATE_W'(rate_threshold_q)) &&
			(chg_mag >= min_change_q);
		restart   = armed_q && (rate_mag > trig_mag);
		total_w   = (end_q > start_q) ? (end_q - start_q) : TIME_W'(1);
		el_w      = (now_q > start_q) ? (now_q - start_q) : '0;
		ramp_end  = (now_q >= end_q);
		num_w     = mdiff_q * el_q;
		ve_prod   = cp_q * RECIP_VE;
	end

	trfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (total_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign sts.fire_arm = fire_arm;
	assign sts.armed    = armed_q;
	assign sts.ramp_end = ramp_end;
	assign sts.div_done = div_done;

	// configuration and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q     <= RATE_SCALE_RST;
			rate_threshold_q <= '0;
			min_change_q     <= '0;
			armed_q          <= 1'b0;
			trig_rate_q      <= '0;
			start_q          <= '0;
			end_q            <= '0;
			start_ve_q       <= VE_UNITY;
			held_q           <= VE_UNITY;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RATE_SCALE:     rate_scale_q     <= cfg_data;
					CFG_RATE_THRESHOLD: rate_threshold_q <= cfg_data;
					CFG_MIN_CHANGE:     min_change_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.decide) begin
				if (fire_arm) begin
					armed_q <= 1'b1;
				end
				if (fire_arm || restart) begin
					trig_rate_q <= rate_q;
					start_q     <= now_q;
					end_q       <= end_new;
					start_ve_q  <= look_q;
					held_q      <= look_q;
				end
			end
			if (cmd.eval && ramp_end) begin
				armed_q <= 1'b0;
				held_q  <= VE_UNITY;
			end
			if (cmd.apply) begin
				held_q <= neg_q ? (start_ve_q - quot) : (start_ve_q + quot);
			end
		end
	end

	// transaction capture, working registers and output register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q   <= now_us;
			tnow_q  <= throttle_now;
			tprev_q <= throttle_prev;
			prim_q  <= primary_ve;
			look_q  <= looked_up_ve;
			bin_q   <= duration_bin;
		end
		if (cmd.rate) begin
			prod_q  <= prod_w;
			binms_q <= BINMS_W'(bin_q) * BIN_MS_NUM;
		end
		if (cmd.scale) begin
			rate_q <= rate_full[RATE_W-1:0];
			ms_q   <= ms_prod[RECIP_MS_SH +: MS_W];
		end
		if (cmd.dur) begin
			dur_q <= dur_prod;
		end
		if (cmd.decide) begin
			written_q <= fire_arm || armed_q;
			comb_q    <= '0;
		end
		if (cmd.eval) begin
			total_q <= total_w;
			el_q    <= el_w;
			neg_q   <= (start_ve_q > VE_UNITY);
			mdiff_q <= (start_ve_q > VE_UNITY) ? (start_ve_q - VE_UNITY) :
				(VE_UNITY - start_ve_q);
		end
		if (cmd.clamp && (el_q > total_q)) begin
			el_q <= total_q;
		end
		if (cmd.mul) begin
			num_q <= num_w;
		end
		if (cmd.comb1) begin
			cp_q <= held_q * prim_q;
		end
		if (cmd.comb2) begin
			comb_q <= (cp_q >= VE_SAT_LIMIT) ? VE_MAX : ve_prod[RECIP_VE_SH +: VE_W];
		end
		if (cmd.load_out) begin
			o_rate_q    <= rate_q;
			o_sec_q     <= held_q;
			o_comb_q    <= comb_q;
			o_written_q <= written_q;
			o_active_q  <= armed_q;
		end
	end

	assign throttle_rate = o_rate_q;
	assign secondary_ve  = o_sec_q;
	assign combined_ve   = o_comb_q;
	assign ve_written    = o_written_q;
	assign enrich_active = o_active_q;

endmodule

FILE: rtl/trfr_ctrl.sv
// Controller: sequences one transaction through the datapath and runs both handshakes.
module trfr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  trfr_pkg::sts_t sts,
	output trfr_pkg::cmd_t cmd
);
	import trfr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RATE,
		S_SCALE,
		S_DUR,
		S_DECIDE,
		S_EVAL,
		S_CLAMP,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_APPLY,
		S_COMB1,
		S_COMB2,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_stall_q <= 1'b1;
						state_q    <= S_RATE;
					end
				end
				S_RATE:   state_q <= S_SCALE;
				S_SCALE:  state_q <= S_DUR;
				S_DUR:    state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.fire_arm) begin
						state_q <= S_COMB1;
					end else if (sts.armed) begin
						state_q <= S_EVAL;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_EVAL:   state_q <= sts.ramp_end ? S_COMB1 : S_CLAMP;
				S_CLAMP:  state_q <= S_MUL;
				S_MUL:    state_q <= S_DIVGO;
				S_DIVGO:  state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY:  state_q <= S_COMB1;
				S_COMB1:  state_q <= S_COMB2;
				S_COMB2:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						in_stall_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.load_in   = in_valid;
			S_RATE:   cmd.rate      = 1'b1;
			S_SCALE:  cmd.scale     = 1'b1;
			S_DUR:    cmd.dur       = 1'b1;
			S_DECIDE: cmd.decide    = 1'b1;
			S_EVAL:   cmd.eval      = 1'b1;
			S_CLAMP:  cmd.clamp     = 1'b1;
			S_MUL:    cmd.mul       = 1'b1;
			S_DIVGO:  cmd.div_start = 1'b1;
			S_APPLY:  cmd.apply     = 1'b1;
			S_COMB1:  cmd.comb1     = 1'b1;
			S_COMB2:  cmd.comb2     = 1'b1;
			S_OUT:    cmd.load_out  = out_free;
			default:  cmd = '0;
		endcase
	end

	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/throttle_rate_fuel_ramp_top.sv
// Top level of the throttle rate fuel ramp: controller, datapath and port assertions.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------------
//  in      | in_valid / in_stall   | now_us, throttle_now, throttle_prev, primary_ve,
//          |                       | looked_up_ve, duration_bin
//  out     | out_valid / out_stall | throttle_rate, secondary_ve, combined_ve,
//          |                       | ve_written, enrich_active
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// One transaction is worked at a time. The result reaches the output register soonest when
// nothing arms, then on a fresh arm, then when a ramp ends, and last while a ramp is running;
// the 8-step ramp divider sets the longest path. The block takes the next transaction in the
// cycle after the result is loaded, even if that result still waits.
// Reset (arst_n low) idles the block with enrichment disarmed, the held secondary VE at 100
// and rate_scale at 30. A stalled earlier result holds the block in its last step until taken.
module throttle_rate_fuel_ramp_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [trfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [trfr_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [trfr_pkg::TIME_W-1:0]          now_us,
	input  logic [trfr_pkg::TP_W-1:0]            throttle_now,
	input  logic [trfr_pkg::TP_W-1:0]            throttle_prev,
	input  logic [trfr_pkg::VE_W-1:0]            primary_ve,
	input  logic [trfr_pkg::VE_W-1:0]            looked_up_ve,
	input  logic [trfr_pkg::VE_W-1:0]            duration_bin,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [trfr_pkg::RATE_W-1:0]   throttle_rate,
	output logic [trfr_pkg::VE_W-1:0]            secondary_ve,
	output logic [trfr_pkg::VE_W-1:0]            combined_ve,
	output logic                                 ve_written,
	output logic                                 enrich_active
);
	import trfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the transaction
	trfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold configuration, ramp state and the arithmetic
	trfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.now_us        (now_us),
		.throttle_now  (throttle_now),
		.throttle_prev (throttle_prev),
		.primary_ve    (primary_ve),
		.looked_up_ve  (looked_up_ve),
		.duration_bin  (duration_bin),
		.throttle_rate (throttle_rate),
		.secondary_ve  (secondary_ve),
		.combined_ve   (combined_ve),
		.ve_written    (ve_written),
		.enrich_active (enrich_active)
	);

	// one transaction in flight: an accepted item closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction is still in work");

	// a new result appears only at the end of a transaction in work
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised with no transaction in work");

	// an idle step writes nothing and leaves enrichment off
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ve_written) |-> (combined_ve == '0 && !enrich_active))
		else $error("idle step reported a VE write or active enrichment");

	// when a written step leaves enrichment off, the ramp has returned to unity
	a_ramp_end_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ve_written && !enrich_active) |-> (secondary_ve == VE_UNITY))
		else $error("ramp ended without returning secondary VE to unity");

endmodule

FILE: bench/throttle_rate_fuel_ramp_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for throttle_rate_fuel_ramp_top: directed table, then random fuel calls.
module throttle_rate_fuel_ramp_top_tb;

	import trfr_pkg::*;

	localparam int HOLD_CYCLES     = 250;     // one long receiver hold-off
	localparam int ITEMS_PER_PHASE = 125;     // six register settings -> about 750 calls
	localparam int N_PHASES        = 6;
	localparam int TAIL_CYCLES     = 45;      // quiet watch for stray results after the final drain
	localparam int CYCLE_LIMIT     = 400000;

	// One engine-loop call as it enters the block.
	typedef struct packed {
		logic [TIME_W-1:0] now_us;
		logic [TP_W-1:0]   thr_now;
		logic [TP_W-1:0]   thr_prev;
		logic [VE_W-1:0]   prim_ve;
		logic [VE_W-1:0]   look_ve;
		logic [VE_W-1:0]   dur_bin;
	} fuel_call_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic signed [RATE_W-1:0] rate;
		logic [VE_W-1:0]          sec_ve;
		logic [VE_W-1:0]          comb_ve;
		logic                     written;
		logic                     active;
	} fuel_result_t;

	// Directed table row: either a register write or a call, with an optional typed result.
	typedef struct packed {
		bit           is_cfg;
		cfg_reg_t     reg_idx;
		logic [CFG_W-1:0] reg_val;
		fuel_call_t   call;
		bit           typed;
		fuel_result_t want;
	} dir_row_t;

	localparam fuel_call_t   NO_CALL   = '0;
	localparam fuel_result_t NO_RESULT = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [TIME_W-1:0] now_us;
	logic [TP_W-1:0] throttle_now;
	logic [TP_W-1:0] throttle_prev;
	logic [VE_W-1:0] primary_ve;
	logic [VE_W-1:0] looked_up_ve;
	logic [VE_W-1:0] duration_bin;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [RATE_W-1:0] throttle_rate;
	logic [VE_W-1:0] secondary_ve;
	logic [VE_W-1:0] combined_ve;
	logic ve_written;
	logic enrich_active;

	throttle_rate_fuel_ramp_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.now_us        (now_us),
		.throttle_now  (throttle_now),
		.throttle_prev (throttle_prev),
		.primary_ve    (primary_ve),
		.looked_up_ve  (looked_up_ve),
		.duration_bin  (duration_bin),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.throttle_rate (throttle_rate),
		.secondary_ve  (secondary_ve),
		.combined_ve   (combined_ve),
		.ve_written    (ve_written),
		.enrich_active (enrich_active)
	);

	// 4 ns clock: rising edges at 2, 6, 10 ...
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the registers and the enrichment state, at their reset values.
	logic [CFG_W-1:0]         rate_scale_q = RATE_SCALE_RST;
	logic [CFG_W-1:0]         rate_thresh_q = '0;
	logic [CFG_W-1:0]         min_change_q = '0;
	logic                     ramp_on = 1'b0;
	logic signed [RATE_W-1:0] trig_rate = '0;
	logic [TIME_W-1:0]        ramp_t0 = '0;
	logic [TIME_W-1:0]        ramp_t1 = '0;
	logic [VE_W-1:0]          ramp_ve0 = VE_UNITY;
	logic [VE_W-1:0]          held_ve = VE_UNITY;

	fuel_result_t ve_expected [$];

	int mismatches;
	int calls_sent;
	int results_seen;
	int ramps_armed;
	int ramps_restarted;
	int ramps_ended;
	int settings_run;
	int cycles;
	int hold_requests;
	int holds_served;
	int hold_left;
	bit steady;

	logic [TIME_W-1:0] clock_us;
	logic [TP_W-1:0]   last_thr;

	function automatic int rate_mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// Capture the secondary VE and the end time; shared by arm and restart.
	function automatic void load_ramp(input fuel_call_t c, input int rate);
		logic [TIME_W-1:0] ms;
		ms = (32'(c.dur_bin) * 32'd392) / 32'd100;
		trig_rate = rate[RATE_W-1:0];
		ramp_t0   = c.now_us;
		ramp_t1   = c.now_us + ms * 32'd1000;
		held_ve   = c.look_ve;
		ramp_ve0  = c.look_ve;
	endfunction

	// Advance the enrichment state by one call and return the result it causes.
	function automatic fuel_result_t predict_fuel_step(input fuel_call_t c);
		int change;
		int rate;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] elapsed;
		longint diff;
		longint delta;
		logic [CP_W-1:0] prod;
		logic [CP_W-1:0] quot;
		fuel_result_t r;
		change = int'(c.thr_now) - int'(c.thr_prev);
		rate = (int'(rate_scale_q) * change) / 2;    // truncates toward zero
		r = NO_RESULT;
		if (!ramp_on && rate_mag(rate) > int'(rate_thresh_q) &&
				rate_mag(change) >= int'(min_change_q)) begin
			ramp_on = 1'b1;
			load_ramp(c, rate);
			ramps_armed++;
			r.written = 1'b1;
		end else if (ramp_on) begin
			if (rate_mag(rate) > rate_mag(int'(trig_rate))) begin
				load_ramp(c, rate);
				ramps_restarted++;
			end
			total   = (ramp_t1 > ramp_t0) ? ramp_t1 - ramp_t0 : 32'd1;
			elapsed = (c.now_us > ramp_t0) ? c.now_us - ramp_t0 : 32'd0;
			if (c.now_us >= ramp_t1) begin
				ramp_on = 1'b0;
				held_ve = VE_UNITY;
				ramps_ended++;
			end else begin
				if (elapsed > total)
					elapsed = total;
				diff  = 64'sd100 - longint'(ramp_ve0);
				delta = (diff * longint'(elapsed)) / longint'(total);
				held_ve = VE_W'(longint'(ramp_ve0) + delta);
			end
			r.written = 1'b1;
		end
		if (r.written) begin
			prod = CP_W'(held_ve) * CP_W'(c.prim_ve);
			quot = prod / CP_W'(VE_UNITY);
			r.comb_ve = (quot > CP_W'(VE_MAX)) ? VE_MAX : quot[VE_W-1:0];
		end
		r.rate   = rate[RATE_W-1:0];
		r.sec_ve = held_ve;
		r.active = ramp_on;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
			$realtime, what, got, want, results_seen);
		mismatches++;
	endtask

	// Offer one call, hold it until accepted, then queue its expected result.
	task automatic offer(input fuel_call_t c, input bit typed, input fuel_result_t want);
		int gap;
		fuel_result_t pred;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 14)
			gap = $urandom_range(1, 6);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		now_us        <= c.now_us;
		throttle_now  <= c.thr_now;
		throttle_prev <= c.thr_prev;
		primary_ve    <= c.prim_ve;
		looked_up_ve  <= c.look_ve;
		duration_bin  <= c.dur_bin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = predict_fuel_step(c);
		ve_expected.push_back(typed ? want : pred);
		calls_sent++;
	endtask

	// Drop valid and hold until every queued result has been taken.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ve_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RATE_SCALE:     rate_scale_q = v;
			CFG_RATE_THRESHOLD: rate_thresh_q = v;
			CFG_MIN_CHANGE:     min_change_q = v;
			default: ;
		endcase
	endtask

	// Receiver: random stalls, a quiet stretch when steady, and a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			out_stall    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 14);
		end
	end

	// Check every accepted result against the oldest expectation.
	always @(posedge clk) begin
		fuel_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (ve_expected.size() == 0) begin
				flag_mismatch("unexpected result", 1, 0);
			end else begin
				want = ve_expected.pop_front();
				if (throttle_rate !== want.rate)
					flag_mismatch("throttle_rate", throttle_rate, want.rate);
				if (secondary_ve !== want.sec_ve)
					flag_mismatch("secondary_ve", secondary_ve, want.sec_ve);
				if (combined_ve !== want.comb_ve)
					flag_mismatch("combined_ve", combined_ve, want.comb_ve);
				if (ve_written !== want.written)
					flag_mismatch("ve_written", ve_written, want.written);
				if (enrich_active !== want.active)
					flag_mismatch("enrich_active", enrich_active, want.active);
			end
			results_seen++;
		end
	end

	// Watchdog: end the run if it ever hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	dir_row_t dir_rows [27];

	initial begin
		fuel_call_t c;
		int t;
		logic [CFG_W-1:0] s_scale;
		logic [CFG_W-1:0] s_thresh;
		logic [CFG_W-1:0] s_minch;

		// Directed table. Typed results are the obvious ones: idle calls, full-scale
		// arms, the zero-duration end and the exact end time. The rest use the predictor.
		dir_rows = '{
			// idle, no change: nothing written
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd1000, 8'd50, 8'd50, 8'd200, 8'd150, 8'd10},
				1'b1, '{16'sd0, 8'd100, 8'd0, 1'b0, 1'b0}},
			// full rising swing arms; combined VE saturates
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd2000, 8'd255, 8'd0, 8'd255, 8'd200, 8'd0},
				1'b1, '{16'sd3825, 8'd200, 8'd255, 1'b1, 1'b1}},
			// zero duration: ends on the next armed call
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd3000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
				1'b1, '{16'sd0, 8'd100, 8'd0, 1'b1, 1'b0}},
			// full falling swing, longest duration, secondary VE of zero
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd4000, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255},
				1'b1, '{-16'sd3825, 8'd0, 8'd0, 1'b1, 1'b1}},
			// halfway up the ramp
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd503500, 8'd100, 8'd100, 8'd255, 8'd255, 8'd255},
				1'b0, NO_RESULT},
			// time before the ramp start counts as zero elapsed
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd3000, 8'd0, 8'd0, 8'd100, 8'd77, 8'd1},
				1'b0, NO_RESULT},
			// equal rate magnitude does not restart
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd700000, 8'd255, 8'd0, 8'd180, 8'd255, 8'd3},
				1'b0, NO_RESULT},
			// exactly at the end time
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd1003000, 8'd7, 8'd7, 8'd100, 8'd10, 8'd10},
				1'b1, '{16'sd0, 8'd100, 8'd100, 1'b1, 1'b0}},
			'{1'b1, CFG_RATE_THRESHOLD, 8'd255, NO_CALL, 1'b0, NO_RESULT},
			'{1'b1, CFG_MIN_CHANGE, 8'd255, NO_CALL, 1'b0, NO_RESULT},
			// rate under threshold
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd1010000, 8'd10, 8'd0, 8'd90, 8'd90, 8'd9},
				1'b1, '{16'sd150, 8'd100, 8'd0, 1'b0, 1'b0}},
			// rate over threshold but change one short of min_change
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd1015000, 8'd254, 8'd0, 8'd90, 8'd90, 8'd9},
				1'b1, '{16'sd3810, 8'd100, 8'd0, 1'b0, 1'b0}},
			// full change arms with secondary VE 255
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd1020000, 8'd0, 8'd255, 8'd100, 8'd255, 8'd10},
				1'b1, '{-16'sd3825, 8'd255, 8'd255, 1'b1, 1'b1}},
			// downward ramp: negative step truncates toward zero
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd1021000, 8'd0, 8'd0, 8'd100, 8'd1, 8'd1},
				1'b0, NO_RESULT},
			'{1'b1, CFG_RATE_THRESHOLD, 8'd0, NO_CALL, 1'b0, NO_RESULT},
			'{1'b1, CFG_MIN_CHANGE, 8'd0, NO_CALL, 1'b0, NO_RESULT},
			// run out the ramp
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd2000000, 8'd0, 8'd0, 8'd128, 8'd2, 8'd2},
				1'b0, NO_RESULT},
			// small arm, then a larger rate restarts
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd2001000, 8'd110, 8'd100, 8'd150, 8'd180, 8'd50},
				1'b0, NO_RESULT},
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd2002000, 8'd100, 8'd120, 8'd150, 8'd60, 8'd20},
				1'b0, NO_RESULT},
			// jump near the top of time: the ramp ends
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'hFFFF_FF00, 8'd0, 8'd0, 8'd99, 8'd3, 8'd3},
				1'b0, NO_RESULT},
			// arm with an end time that wraps past zero
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'hFFFF_FF10, 8'd200, 8'd100, 8'd99, 8'd130, 8'd100},
				1'b0, NO_RESULT},
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'hFFFF_FF20, 8'd0, 8'd0, 8'd99, 8'd4, 8'd4},
				1'b0, NO_RESULT},
			'{1'b1, CFG_RATE_SCALE, 8'd0, NO_CALL, 1'b0, NO_RESULT},
			// rate_scale of zero never arms
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd100, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255},
				1'b1, '{16'sd0, 8'd100, 8'd0, 1'b0, 1'b0}},
			'{1'b1, CFG_RATE_SCALE, 8'd1, NO_CALL, 1'b0, NO_RESULT},
			// scale 1, change -1: half of -1 truncates to zero
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd200, 8'd0, 8'd1, 8'd50, 8'd50, 8'd5},
				1'b1, '{16'sd0, 8'd100, 8'd0, 1'b0, 1'b0}},
			// scale 1, change -3: rate -1 arms
			'{1'b0, CFG_RATE_SCALE, 8'd0, '{32'd300, 8'd0, 8'd3, 8'd50, 8'd160, 8'd5},
				1'b0, NO_RESULT}
		};

		// Drive every input to a known value with reset held low, then release reset.
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_RATE_SCALE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		now_us        = '0;
		throttle_now  = '0;
		throttle_prev = '0;
		primary_ve    = '0;
		looked_up_ve  = '0;
		duration_bin  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table; register writes go in only while the block is idle.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_drained();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				offer(dir_rows[i].call, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random part: one register setting per phase, extremes among them.
		clock_us = 32'd5000000;
		last_thr = 8'd40;
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin s_scale = 8'd30;  s_thresh = 8'd0;   s_minch = 8'd0;   end
				1: begin s_scale = 8'd255; s_thresh = 8'd255; s_minch = 8'd255; end
				2: begin s_scale = 8'd1;   s_thresh = 8'd0;   s_minch = 8'd0;   end
				3: begin
					s_scale  = $urandom_range(1, 255);
					s_thresh = $urandom_range(0, 40);
					s_minch  = $urandom_range(0, 20);
				end
				4: begin s_scale = 8'd255; s_thresh = 8'd0;   s_minch = 8'd0;   end
				default: begin
					s_scale  = $urandom_range(1, 255);
					s_thresh = $urandom_range(0, 255);
					s_minch  = $urandom_range(0, 255);
				end
			endcase
			write_reg(CFG_RATE_SCALE, s_scale);
			write_reg(CFG_RATE_THRESHOLD, s_thresh);
			write_reg(CFG_MIN_CHANGE, s_minch);
			settings_run++;
			steady = (p == 2);    // a whole phase with no idling on either side

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Stall the receiver for a long stretch while calls keep coming.
				if (p == 4 && k == 20)
					hold_requests++;
				// Pause the sender until the block has handed over everything.
				if (p == 3 && k == 60)
					wait_drained();

				if ($urandom_range(0, 99) < 82) begin
					// Well-formed loop: time moves forward, throttle follows its last reading.
					if ($urandom_range(0, 19) == 0)
						clock_us = clock_us + $urandom_range(0, 400000);
					else
						clock_us = clock_us + $urandom_range(0, 6000);
					c.now_us   = clock_us;
					c.thr_prev = last_thr;
					case ($urandom_range(0, 9))
						0, 1: c.thr_now = $urandom_range(0, 255);
						2: c.thr_now = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
						default: begin
							t = int'(last_thr) + int'($urandom_range(0, 8)) - 4;
							if (t < 0)
								t = 0;
							if (t > 255)
								t = 255;
							c.thr_now = t[TP_W-1:0];
						end
					endcase
					c.prim_ve = $urandom_range(0, 255);
					c.look_ve = $urandom_range(0, 255);
					c.dur_bin = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 30);
					last_thr = c.thr_now;
				end else begin
					// Noise: every field free, time anywhere.
					c.now_us   = $urandom;
					c.thr_now  = $urandom_range(0, 255);
					c.thr_prev = $urandom_range(0, 255);
					c.prim_ve  = $urandom_range(0, 255);
					c.look_ve  = $urandom_range(0, 255);
					c.dur_bin  = $urandom_range(0, 255);
				end
				offer(c, 1'b0, NO_RESULT);
			end
		end

		// Drain, then watch a while longer for stray results.
		steady = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ve_expected.size() != 0)
			flag_mismatch("results never delivered", 0, ve_expected.size());

		$display("Sent %0d fuel calls over %0d register settings, %0d results checked.",
			calls_sent, settings_run + 1, results_seen);
		$display("Ramps armed %0d, restarted %0d, ended %0d; %0d mismatches.",
			ramps_armed, ramps_restarted, ramps_ended, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: throttle_rate_fuel_ramp_top.f
rtl/trfr_pkg.sv
rtl/trfr_div.sv
rtl/trfr_dp.sv
rtl/trfr_ctrl.sv
rtl/throttle_rate_fuel_ramp_top.sv
bench/throttle_rate_fuel_ramp_top_tb.sv
